FILE: rtl/core/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared constants and types for the telnet command stripper.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int unsigned ByteW = 8;

    localparam logic [ByteW-1:0] TEL_IAC = 8'd255;
    localparam logic [ByteW-1:0] TEL_SB  = 8'd250;
    localparam logic [ByteW-1:0] TEL_SE  = 8'd240;
    localparam logic [ByteW-1:0] CH_CR   = 8'h0D;
    localparam logic [ByteW-1:0] CH_LF   = 8'h0A;

    // Parser phase, one-hot.
    typedef enum logic [6:0] {
        PH_NORMAL   = 7'b0000001,
        PH_AFTER_CR = 7'b0000010,
        PH_IAC      = 7'b0000100,
        PH_CMD_OPT  = 7'b0001000,
        PH_SB_OPT   = 7'b0010000,
        PH_SB_BODY  = 7'b0100000,
        PH_SB_IAC   = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_phase           next_phase;
        logic             emit;
        logic [ByteW-1:0] data;
    } t_parse_result;

endpackage

FILE: rtl/core/tcs_parser.sv
// ----------------------------------------------------------------------------
// tcs_parser
// Next-phase and output decision for one telnet stream word.
// ----------------------------------------------------------------------------
module tcs_parser (
    input  tcs_pkg::t_phase              i_phase,
    input  logic [tcs_pkg::ByteW-1:0]    i_byte,
    output tcs_pkg::t_parse_result       o_result
);

    tcs_pkg::t_parse_result w_plain;

    // Handling of a word in the normal data phase.
    always_comb begin
        w_plain.emit = 1'b1;
        w_plain.data = i_byte;
        w_plain.next_phase = tcs_pkg::PH_NORMAL;
        if (i_byte == tcs_pkg::TEL_IAC) begin
            w_plain.emit = 1'b0;
            w_plain.next_phase = tcs_pkg::PH_IAC;
        end else if (i_byte == tcs_pkg::CH_CR) begin
            w_plain.data = tcs_pkg::CH_LF;
            w_plain.next_phase = tcs_pkg::PH_AFTER_CR;
        end
    end

    always_comb begin
        o_result.emit = 1'b0;
        o_result.data = i_byte;
        o_result.next_phase = i_phase;
        unique case (i_phase)
            tcs_pkg::PH_AFTER_CR: begin
                if (i_byte == tcs_pkg::CH_LF) begin
                    o_result.next_phase = tcs_pkg::PH_NORMAL;
                end else begin
                    o_result = w_plain;
                end
            end
            tcs_pkg::PH_IAC: begin
                if (i_byte == tcs_pkg::TEL_IAC) begin
                    o_result.emit = 1'b1;
                    o_result.data = tcs_pkg::TEL_IAC;
                    o_result.next_phase = tcs_pkg::PH_NORMAL;
                end else if (i_byte == tcs_pkg::TEL_SB) begin
                    o_result.next_phase = tcs_pkg::PH_SB_OPT;
                end else begin
                    o_result.next_phase = tcs_pkg::PH_CMD_OPT;
                end
            end
            tcs_pkg::PH_CMD_OPT: begin
                o_result.next_phase = tcs_pkg::PH_NORMAL;
            end
            tcs_pkg::PH_SB_OPT: begin
                // The option word is skipped without looking at it.
                o_result.next_phase = tcs_pkg::PH_SB_BODY;
            end
            tcs_pkg::PH_SB_BODY: begin
                if (i_byte == tcs_pkg::TEL_IAC) begin
                    o_result.next_phase = tcs_pkg::PH_SB_IAC;
                end
            end
            tcs_pkg::PH_SB_IAC: begin
                // A repeated IAC keeps waiting for SE.
                if (i_byte == tcs_pkg::TEL_SE) begin
                    o_result.next_phase = tcs_pkg::PH_NORMAL;
                end else if (i_byte != tcs_pkg::TEL_IAC) begin
                    o_result.next_phase = tcs_pkg::PH_SB_BODY;
                end
            end
            default: begin
                o_result = w_plain;
            end
        endcase
    end

endmodule

FILE: rtl/core/telnet_command_stripper.sv
// ----------------------------------------------------------------------------
// telnet_command_stripper
// Removes telnet commands from a byte stream and passes the user data on.
// ----------------------------------------------------------------------------
// At most one word enters and at most one word leaves per cycle. Each word
// is captured in an input register, decoded against the parser phase
// combinationally, and its result lands in an output register, which drives
// output valid. The sustained rate is one word per clock while the output
// side does not stall. Plain words pass through, CR leaves as LF and a
// directly following LF is dropped, IAC IAC yields one 255 word,
// subnegotiations up to IAC SE are dropped, and any other IAC command is
// dropped together with its command and option words.
module telnet_command_stripper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tcs_pkg::ByteW-1:0]     i_in_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcs_pkg::ByteW-1:0]     o_out_byte
);

    logic                         r_in_valid;
    logic                         n_in_valid;
    logic [tcs_pkg::ByteW-1:0]    r_in_byte;
    tcs_pkg::t_phase              r_phase;
    logic                         r_out_valid;
    logic [tcs_pkg::ByteW-1:0]    r_out_byte;
    logic                         w_out_free;
    logic                         w_adv;
    logic                         w_in_acc;
    tcs_pkg::t_parse_result       w_res;

    tcs_parser u_parser (
        .i_phase  (r_phase),
        .i_byte   (r_in_byte),
        .o_result (w_res)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_acc) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= tcs_pkg::PH_NORMAL;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (w_adv) begin
                r_phase <= w_res.next_phase;
            end
            if (w_out_free) begin
                r_out_valid <= w_adv && w_res.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_in_byte;
        end
        if (w_adv && w_res.emit) begin
            r_out_byte <= w_res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

    // An emitted result must show up on the output in the next cycle.
    a_emit_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_res.emit) |=> o_out_valid)
        else $error("emitted word did not reach the output register");

    // IAC IAC produces a single 255 word.
    a_iac_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_phase == tcs_pkg::PH_IAC && r_in_byte == tcs_pkg::TEL_IAC)
        |=> (o_out_valid && o_out_byte == tcs_pkg::TEL_IAC))
        else $error("escaped IAC not delivered as 255");

    // Nothing leaves while a command or subnegotiation is being skipped.
    a_no_emit_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_phase == tcs_pkg::PH_CMD_OPT || r_phase == tcs_pkg::PH_SB_OPT
            || r_phase == tcs_pkg::PH_SB_BODY || r_phase == tcs_pkg::PH_SB_IAC))
        |-> !w_res.emit)
        else $error("word emitted inside a command");

    // CR is always mapped to LF, so it never appears on the output.
    a_no_cr_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_byte != tcs_pkg::CH_CR))
        else $error("CR word on the output");

endmodule
